### hdl/glcp_pkg.sv
package glcp_pkg;

  // Header codes
  localparam logic [7:0] HdrRowMask   = 8'hF0;
  localparam logic [7:0] HdrRow       = 8'h70;
  localparam logic [7:0] HdrLevelQuad = 8'h1A;
  localparam logic [7:0] HdrBitQuad   = 8'h80;

  // Byte positions within a command
  localparam logic [5:0] PosHeader     = 6'd0;
  localparam logic [5:0] PosFirst      = 6'd1;
  localparam logic [5:0] PosQuadX      = 6'd1;
  localparam logic [5:0] PosQuadY      = 6'd2;
  localparam logic [5:0] PosLevelData  = 6'd3;
  localparam logic [5:0] LevelQuadLast = 6'd34;
  localparam logic [5:0] BitQuadLast   = 6'd8;

  localparam int unsigned LevelsW = 256;

  typedef enum logic {
    KindRow  = 1'b0,
    KindQuad = 1'b1
  } update_kind_e;

  typedef struct packed {
    update_kind_e       kind;
    logic [7:0]         x_offset;
    logic [7:0]         y_offset;
    logic [7:0]         row_bits;
    logic [LevelsW-1:0] levels;
  } result_t;

endpackage

### hdl/glcp_parser.sv
module glcp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_message_i,
  output logic              res_valid_o,
  output glcp_pkg::result_t res_o
);
  import glcp_pkg::*;

  logic [5:0]         pos_q, pos_d;
  logic [7:0]         hdr_q, hdr_d;
  logic [7:0]         qx_q, qx_d;
  logic [7:0]         qy_q, qy_d;
  logic [LevelsW-1:0] store_q, store_d;
  logic               skip_q, skip_d;

  logic               is_row_hdr;
  logic               known_hdr;
  logic [4:0]         lvl_idx;
  logic [2:0]         bit_idx;
  logic [7:0]         pair;
  logic [31:0]        onoff;

  assign is_row_hdr = (hdr_q & HdrRowMask) == HdrRow;
  assign known_hdr  = ((data_byte_i & HdrRowMask) == HdrRow) ||
                      (data_byte_i == HdrLevelQuad) ||
                      ((data_byte_i & HdrBitQuad) != 8'h00);
  assign lvl_idx    = 5'(pos_q - PosLevelData);
  assign bit_idx    = 3'(pos_q - PosFirst);
  // Swap nibbles: the high nibble is the lower-numbered LED
  assign pair       = {data_byte_i[3:0], data_byte_i[7:4]};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      onoff[i*4 +: 4] = {4{data_byte_i[i]}};
    end
  end

  always_comb begin
    pos_d       = pos_q;
    hdr_d       = hdr_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    store_d     = store_q;
    skip_d      = skip_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (skip_q) begin
      // drop until end of message
    end else if (pos_q == PosHeader) begin
      hdr_d = data_byte_i;
      if (known_hdr) begin
        pos_d   = PosFirst;
        store_d = '0;
      end else begin
        skip_d = 1'b1;
      end
    end else if (is_row_hdr) begin
      res_valid_o    = 1'b1;
      res_o.kind     = KindRow;
      res_o.y_offset = {4'h0, hdr_q[3:0]};
      res_o.row_bits = data_byte_i;
      pos_d          = PosHeader;
    end else if (hdr_q == HdrLevelQuad) begin
      if (pos_q == PosQuadX) begin
        qx_d = data_byte_i;
      end else if (pos_q == PosQuadY) begin
        qy_d = data_byte_i;
      end else begin
        store_d[{lvl_idx, 3'b000} +: 8] = store_q[{lvl_idx, 3'b000} +: 8] | pair;
      end
      if (pos_q >= LevelQuadLast) begin
        res_valid_o    = 1'b1;
        res_o.kind     = KindQuad;
        res_o.x_offset = qx_q;
        res_o.y_offset = qy_q;
        res_o.levels   = store_d;
        skip_d         = 1'b1;
        pos_d          = PosHeader;
      end else begin
        pos_d = pos_q + 6'd1;
      end
    end else begin
      store_d[{bit_idx, 5'b00000} +: 32] = store_q[{bit_idx, 5'b00000} +: 32] | onoff;
      if (pos_q >= BitQuadLast) begin
        res_valid_o    = 1'b1;
        res_o.kind     = KindQuad;
        res_o.x_offset = {4'h0, hdr_q[0], 3'b000};
        res_o.y_offset = {4'h0, hdr_q[1], 3'b000};
        res_o.levels   = store_d;
        skip_d         = 1'b1;
        pos_d          = PosHeader;
      end else begin
        pos_d = pos_q + 6'd1;
      end
    end

    if (end_of_message_i) begin
      pos_d  = PosHeader;
      skip_d = 1'b0;
    end

    res_valid_o = res_valid_o && accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosHeader;
      hdr_q   <= '0;
      qx_q    <= '0;
      qy_q    <= '0;
      store_q <= '0;
      skip_q  <= 1'b0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      qx_q    <= qx_d;
      qy_q    <= qy_d;
      store_q <= store_d;
      skip_q  <= skip_d;
    end
  end

endmodule

### hdl/glcp_skid.sv
module glcp_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  glcp_pkg::result_t in_data_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output glcp_pkg::result_t out_data_o,
  input  logic              out_stall_i
);
  import glcp_pkg::*;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || !out_stall_i) begin
      // output slot frees up: refill from skid first, then from input
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = in_data_i;
        main_valid_d = in_valid_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

### hdl/grid_led_command_parser.sv
// Each result is registered in the output or skid stage. Throughput: one byte per
// cycle while in_stall_o is low; the parser state updates in the accepting cycle.
// in_stall_o rises only when two results are waiting in the output skid stage.
// Reset (asynchronous, active low): parser awaits a header, level store cleared,
// output and skid stages empty.
module grid_led_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        update_kind_o,
  output logic [7:0]  x_offset_o,
  output logic [7:0]  y_offset_o,
  output logic [7:0]  row_bits_o,
  output logic [63:0] levels_0_o,
  output logic [63:0] levels_1_o,
  output logic [63:0] levels_2_o,
  output logic [63:0] levels_3_o
);
  import glcp_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Take a byte whenever the skid stage has room; the parser state advances
  // on every accepted beat, whether or not the byte completes a command.
  assign accept = in_valid_i && !in_stall_o;

  // Header decode, position tracking and quadrant level gathering. Produces
  // at most one update per beat, combinationally from the current byte.
  glcp_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  // Output register plus one skid entry, so the parser keeps taking bytes
  // while a finished update waits on a stalled consumer.
  glcp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res),
    .out_stall_i (out_stall_i)
  );

  // Split the registered update onto the payload ports
  assign update_kind_o = out_res.kind;
  assign x_offset_o    = out_res.x_offset;
  assign y_offset_o    = out_res.y_offset;
  assign row_bits_o    = out_res.row_bits;
  assign levels_0_o    = out_res.levels[63:0];
  assign levels_1_o    = out_res.levels[127:64];
  assign levels_2_o    = out_res.levels[191:128];
  assign levels_3_o    = out_res.levels[255:192];

endmodule

### tb/grid_led_command_parser_tb.sv
module grid_led_command_parser_tb;
  import glcp_pkg::*;

  localparam int RandomBeats = 1950;
  localparam int CalmBeats   = 200;
  localparam int HoldEvery   = 500;
  localparam int CycleLimit  = 200000;
  localparam int ReportMax   = 10;

  // One LED update as the parser presents it on its output ports
  typedef struct packed {
    update_kind_e     kind;
    logic [7:0]       x_off;
    logic [7:0]       y_off;
    logic [7:0]       row;
    logic [3:0][63:0] levels;
  } led_update_t;

  // One pending input beat; hold marks a pause until all updates have drained
  typedef struct packed {
    logic [7:0] data;
    logic       eom;
    logic       hold;
  } serial_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        update_kind;
  logic [7:0]  x_offset;
  logic [7:0]  y_offset;
  logic [7:0]  row_bits;
  logic [63:0] levels_0;
  logic [63:0] levels_1;
  logic [63:0] levels_2;
  logic [63:0] levels_3;

  grid_led_command_parser i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .end_of_message_i (end_of_message),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .update_kind_o    (update_kind),
    .x_offset_o       (x_offset),
    .y_offset_o       (y_offset),
    .row_bits_o       (row_bits),
    .levels_0_o       (levels_0),
    .levels_1_o       (levels_1),
    .levels_2_o       (levels_2),
    .levels_3_o       (levels_3)
  );

  always #4 clk_i = ~clk_i;

  serial_beat_t pending_q[$];
  led_update_t  upd_q[$];
  logic [7:0]   msg_q[$];

  int total_beats = 0;
  int beats_taken = 0;
  int mismatches = 0;
  int row_updates = 0;
  int quad_updates = 0;
  int cycles = 0;
  int idle_odds = 0;
  int gap_cnt = 0;
  int stall_cnt = 0;
  int settle_cnt = 0;

  // Parser state mirrored by the predictor
  logic [5:0]       pos_q = PosHeader;
  logic [7:0]       hdr_q = 8'h00;
  logic [7:0]       qx_q = 8'h00;
  logic [7:0]       qy_q = 8'h00;
  logic [3:0][63:0] lvl_q = '0;
  logic             skip_q = 1'b0;

  // Advance the parser model by one accepted byte; queue the update it completes.
  task automatic parse_byte(input logic [7:0] b, input logic eom);
    led_update_t upd;
    logic [63:0] chunk;
    int          idx;
    upd = '0;
    if (skip_q) begin
      // drop the rest of the message
    end else if (pos_q == PosHeader) begin
      hdr_q = b;
      if ((b & HdrRowMask) == HdrRow || b == HdrLevelQuad || (b & HdrBitQuad) != 8'h00) begin
        pos_q = PosFirst;
        lvl_q = '0;
      end else begin
        skip_q = 1'b1;
      end
    end else if ((hdr_q & HdrRowMask) == HdrRow) begin
      upd.kind  = KindRow;
      upd.y_off = {4'h0, hdr_q[3:0]};
      upd.row   = b;
      upd_q.push_back(upd);
      pos_q = PosHeader;
    end else if (hdr_q == HdrLevelQuad) begin
      if (pos_q == PosQuadX) begin
        qx_q = b;
      end else if (pos_q == PosQuadY) begin
        qy_q = b;
      end else begin
        // two LEDs per byte, high nibble lands on the lower LED
        idx   = int'(pos_q - PosLevelData);
        chunk = {56'h0, b[3:0], b[7:4]};
        lvl_q[(idx >> 3) & 3] = lvl_q[(idx >> 3) & 3] | (chunk << ((idx & 7) * 8));
      end
      if (pos_q >= LevelQuadLast) begin
        upd.kind   = KindQuad;
        upd.x_off  = qx_q;
        upd.y_off  = qy_q;
        upd.levels = lvl_q;
        upd_q.push_back(upd);
        skip_q = 1'b1;
        pos_q  = PosHeader;
      end else begin
        pos_q = pos_q + 6'd1;
      end
    end else begin
      // on/off quadrant: each set bit becomes full level
      idx   = int'(pos_q - PosFirst);
      chunk = '0;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) chunk[i*4 +: 4] = 4'hF;
      end
      lvl_q[(idx >> 1) & 3] = lvl_q[(idx >> 1) & 3] | (chunk << ((idx & 1) * 32));
      if (pos_q >= BitQuadLast) begin
        upd.kind   = KindQuad;
        upd.x_off  = {4'h0, hdr_q[0], 3'b000};
        upd.y_off  = {4'h0, hdr_q[1], 3'b000};
        upd.levels = lvl_q;
        upd_q.push_back(upd);
        skip_q = 1'b1;
        pos_q  = PosHeader;
      end else begin
        pos_q = pos_q + 6'd1;
      end
    end
    if (eom) begin
      pos_q  = PosHeader;
      skip_q = 1'b0;
    end
  endtask

  // Move the built message into the pending beats; mark its last byte if closed.
  task automatic flush_msg(input bit close);
    serial_beat_t beat;
    foreach (msg_q[k]) begin
      beat.data = msg_q[k];
      beat.eom  = close && (k == msg_q.size() - 1);
      beat.hold = 1'b0;
      pending_q.push_back(beat);
    end
    total_beats += msg_q.size();
    msg_q.delete();
  endtask

  task automatic push_hold();
    serial_beat_t beat;
    beat = '0;
    beat.hold = 1'b1;
    pending_q.push_back(beat);
  endtask

  // Cycle counter: pick a new idle density now and then, kill a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 0) begin
      case ($urandom_range(0, 2))
        0:       idle_odds <= 0;
        1:       idle_odds <= 4;
        default: idle_odds <= 16;
      endcase
    end
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d updates still awaited", cycles, upd_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Driver: hold a stalled beat, otherwise idle in bursts or present the next beat.
  always @(posedge clk_i) begin
    serial_beat_t beat;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // hold the payload until it is taken
    end else if (gap_cnt != 0) begin
      in_valid <= 1'b0;
      gap_cnt = gap_cnt - 1;
    end else if (pending_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (pending_q[0].hold) begin
      // pause the sender until the output side has drained
      in_valid <= 1'b0;
      if (upd_q.size() == 0 && !out_valid) begin
        settle_cnt = settle_cnt + 1;
        if (settle_cnt >= 4) begin
          void'(pending_q.pop_front());
          settle_cnt = 0;
        end
      end else begin
        settle_cnt = 0;
      end
    end else if (idle_odds != 0 && pending_q.size() >= CalmBeats &&
                 $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      gap_cnt = $urandom_range(0, 4);
    end else begin
      beat = pending_q.pop_front();
      in_valid       <= 1'b1;
      data_byte      <= beat.data;
      end_of_message <= beat.eom;
    end
  end

  // Receiver stall: random bursts, none once the stimulus is nearly done.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (stall_cnt != 0) begin
      out_stall <= 1'b1;
      stall_cnt = stall_cnt - 1;
    end else if (idle_odds != 0 && pending_q.size() >= CalmBeats &&
                 $urandom_range(1, idle_odds) == 1) begin
      out_stall <= 1'b1;
      stall_cnt = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: check the output beat first, then predict from the input beat of
  // the same edge, so an update is never checked against its own cause.
  always @(posedge clk_i) begin
    led_update_t got;
    led_update_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        got.kind   = update_kind_e'(update_kind);
        got.x_off  = x_offset;
        got.y_off  = y_offset;
        got.row    = row_bits;
        got.levels = {levels_3, levels_2, levels_1, levels_0};
        if (got.kind == KindRow) row_updates++;
        else quad_updates++;
        if (upd_q.size() == 0) begin
          if (mismatches < ReportMax)
            $display("Unexpected update at cycle %0d: kind %0d x %h y %h row %h levels %h",
                     cycles, got.kind, got.x_off, got.y_off, got.row, got.levels);
          mismatches++;
        end else begin
          want = upd_q.pop_front();
          if (got.kind !== want.kind || got.x_off !== want.x_off ||
              got.y_off !== want.y_off || got.row !== want.row ||
              got.levels[0] !== want.levels[0] || got.levels[1] !== want.levels[1] ||
              got.levels[2] !== want.levels[2] || got.levels[3] !== want.levels[3]) begin
            if (mismatches < ReportMax) begin
              $display("Wrong update at cycle %0d", cycles);
              $display("  expected kind %0d x %h y %h row %h levels %h",
                       want.kind, want.x_off, want.y_off, want.row, want.levels);
              $display("  actual   kind %0d x %h y %h row %h levels %h",
                       got.kind, got.x_off, got.y_off, got.row, got.levels);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(data_byte, end_of_message);
        beats_taken++;
      end
    end
  end

  initial begin
    int next_hold;
    int n;
    // Directed: row extremes and repeats, device info, unknown header, short
    // commands and an on/off quadrant with a trailing byte to be dropped.
    msg_q = '{8'h70, 8'h00, 8'h7F, 8'hFF, 8'h7A, 8'h5A};
    flush_msg(1'b1);
    msg_q = '{8'h01, 8'h7F};
    flush_msg(1'b1);
    msg_q = '{8'h20, 8'h70, 8'h11};
    flush_msg(1'b1);
    msg_q = '{8'h75};
    flush_msg(1'b1);
    msg_q = '{8'h83, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h0F, 8'hF0, 8'h70};
    flush_msg(1'b1);
    msg_q = '{8'h1A};
    flush_msg(1'b1);
    msg_q = '{8'h81, 8'h12};
    flush_msg(1'b1);
    push_hold();

    // Random: mostly well-formed messages with random content, some noise.
    next_hold = total_beats + HoldEvery;
    n = total_beats;
    while (total_beats < n + RandomBeats) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // row pairs, sometimes followed by an on/off quadrant
          repeat ($urandom_range(1, 4)) begin
            msg_q.push_back({4'h7, 4'($urandom_range(0, 15))});
            msg_q.push_back(8'($urandom));
          end
          if ($urandom_range(0, 3) == 0) begin
            msg_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
            repeat (8) msg_q.push_back(8'($urandom));
          end
          flush_msg(1'b1);
        end
        3, 4: begin
          msg_q.push_back(HdrLevelQuad);
          repeat (34) msg_q.push_back(8'($urandom));
          repeat ($urandom_range(0, 2)) msg_q.push_back(8'($urandom));
          flush_msg(1'b1);
        end
        5, 6: begin
          msg_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
          repeat (8) msg_q.push_back(8'($urandom));
          repeat ($urandom_range(0, 2)) msg_q.push_back(8'($urandom));
          flush_msg(1'b1);
        end
        7: begin
          // cut a quadrant command short
          if ($urandom_range(0, 1) == 0) begin
            msg_q.push_back(HdrLevelQuad);
            repeat (34) msg_q.push_back(8'($urandom));
          end else begin
            msg_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
            repeat (8) msg_q.push_back(8'($urandom));
          end
          repeat ($urandom_range(1, msg_q.size() - 1)) void'(msg_q.pop_back());
          flush_msg(1'b1);
        end
        8: begin
          // device info request or an unknown header, rest to be dropped
          if ($urandom_range(0, 1) == 0) msg_q.push_back(8'h01);
          else msg_q.push_back(8'($urandom_range(0, 8'h6F)));
          repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom));
          flush_msg(1'b1);
        end
        default: begin
          // raw noise; an open end runs into the next message
          repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom));
          flush_msg(1'($urandom_range(0, 1)));
        end
      endcase
      if (total_beats >= next_hold) begin
        push_hold();
        next_hold = total_beats + HoldEvery;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken < total_beats) @(posedge clk_i);
    while (upd_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    mismatches += upd_q.size();

    $display("Sent %0d serial beats with random gaps and receiver stalls;", total_beats);
    $display("checked %0d row and %0d quadrant updates.", row_updates, quad_updates);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching updates", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
hdl/glcp_pkg.sv
hdl/glcp_parser.sv
hdl/glcp_skid.sv
hdl/grid_led_command_parser.sv
tb/grid_led_command_parser_tb.sv
